[sv/jls_pkg.sv]
// Shared constants, codes and types of the Jacobi linear solver.
package jls_pkg;

    localparam int MAX_UNKNOWNS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 24;

    localparam int SIZE_W   = 5;
    localparam int TOL_W    = 31;
    localparam int SWEEP_W  = 16;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int DIVD_W   = 63;

    localparam logic [SIZE_W-1:0]  SIZE_RST  = 5'd16;
    localparam logic [TOL_W-1:0]   TOL_RST   = 31'd168;
    localparam logic [SWEEP_W-1:0] LIMIT_RST = 16'd1000;

    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_TOL   = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIAG = 2'd2;

    typedef struct packed {
        logic load_old;
        logic rotate_old;
        logic copy_new;
        logic shift_new;
        logic load_rhs;
        logic rotate_rhs;
    } cell_ctrl_t;

endpackage

[sv/jls_ram.sv]
// Generic single-port-write, registered-read RAM.
module jls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/jls_cell.sv]
// One solver cell: old guess, new estimate and right-hand side of one unknown.
module jls_cell (
    input  logic                     clk,
    input  jls_pkg::cell_ctrl_t      ctrl,
    input  logic signed [31:0]       load_data,
    input  logic signed [31:0]       old_in,
    input  logic signed [31:0]       new_in,
    input  logic signed [31:0]       rhs_in,
    output logic signed [31:0]       old_out,
    output logic signed [31:0]       new_out,
    output logic signed [31:0]       rhs_out
);

    logic signed [31:0] old_reg;
    logic signed [31:0] new_reg;
    logic signed [31:0] rhs_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_old)
        begin
            old_reg <= load_data;
        end
        else if (ctrl.copy_new)
        begin
            old_reg <= new_reg;
        end
        else if (ctrl.rotate_old)
        begin
            old_reg <= old_in;
        end
        if (ctrl.shift_new)
        begin
            new_reg <= new_in;
        end
        if (ctrl.load_rhs)
        begin
            rhs_reg <= load_data;
        end
        else if (ctrl.rotate_rhs)
        begin
            rhs_reg <= rhs_in;
        end
    end

    assign old_out = old_reg;
    assign new_out = new_reg;
    assign rhs_out = rhs_reg;

endmodule

[sv/jls_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module jls_div #(
    parameter int DW = 63,
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dsr_reg;
    logic [VW-1:0] rem_reg;
    logic [VW:0]   rem2;
    logic [VW:0]   rem_next;
    logic          ge;

    assign rem2     = {rem_reg, dvd_reg[DW-1]};
    assign ge       = rem2 >= {1'b0, dsr_reg};
    assign rem_next = ge ? rem2 - {1'b0, dsr_reg} : rem2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            rem_reg <= VW'(rem_next);
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[sv/jls_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
module jls_sqrt #(
    parameter int RW = 68
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [RW-1:0]   radicand,
    output logic            busy,
    output logic [RW/2-1:0] root
);

    localparam int HW = RW / 2;
    localparam int CW = $clog2(HW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] rad_reg;
    logic [HW:0]   rem_reg;
    logic [HW-1:0] root_reg;
    logic [HW+2:0] rem2;
    logic [HW+2:0] trial;
    logic [HW+2:0] rem_next;
    logic          ge;

    assign rem2     = {rem_reg, rad_reg[RW-1:RW-2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign ge       = rem2 >= trial;
    assign rem_next = ge ? rem2 - trial : rem2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(HW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RW-3:0], 2'b00};
            rem_reg  <= (HW + 1)'(rem_next);
            root_reg <= {root_reg[HW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[sv/jacobi_linear_solver.sv]
// Jacobi iterative linear solver top level: load, cell chain, sweep control, output.
// Loading takes one value per cycle while idle; the diagonal check follows the transfer with last.
// Each sweep row: multiply-accumulate, setup in S_NUMER and S_DIV_GO, then the shared divider.
// After a sweep the norms are summed, then two square roots are taken in turn and one decision state.
// Each result is held until accepted; no input is taken until the last result is out.
// Reset (rst_n, asynchronous) restores control registers and the load position; stores keep data.
module jacobi_linear_solver #(
    parameter int MAX_UNKNOWNS  = jls_pkg::MAX_UNKNOWNS_DEF,
    parameter int FRACTION_BITS = jls_pkg::FRACTION_BITS_DEF,
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jls_pkg::PADDR_W-1:0]   paddr,
    input  logic [jls_pkg::PDATA_W-1:0]   pwdata,
    output logic [jls_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            value,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [IDX_W-1:0]              index,
    output logic signed [31:0]            solution,
    output logic [jls_pkg::SWEEP_W-1:0]   sweeps,
    output logic [jls_pkg::STATUS_W-1:0]  status,
    output logic                          final_res
);

    localparam int CNT_W  = $clog2(MAX_UNKNOWNS + 2);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int SQ_W   = 64 + 2 * ((IDX_W + 1) / 2);
    localparam int RT_W   = SQ_W / 2;
    localparam logic [63:0] NUM_LIM = 64'(1) << (62 - FRACTION_BITS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHK      = 4'd1;
    localparam logic [3:0] S_MAC      = 4'd2;
    localparam logic [3:0] S_NUMER    = 4'd3;
    localparam logic [3:0] S_DIV_GO   = 4'd4;
    localparam logic [3:0] S_DIV_WAIT = 4'd5;
    localparam logic [3:0] S_NORM     = 4'd6;
    localparam logic [3:0] S_SQO_GO   = 4'd7;
    localparam logic [3:0] S_SQO_WAIT = 4'd8;
    localparam logic [3:0] S_SQN_GO   = 4'd9;
    localparam logic [3:0] S_SQN_WAIT = 4'd10;
    localparam logic [3:0] S_DECIDE   = 4'd11;
    localparam logic [3:0] S_EMIT     = 4'd12;
    localparam logic [3:0] S_EMIT_W   = 4'd13;

    logic [jls_pkg::SIZE_W-1:0]   size_reg;
    logic [jls_pkg::TOL_W-1:0]    tol_reg;
    logic [jls_pkg::SWEEP_W-1:0]  limit_reg;
    logic [3:0]                   state_reg;
    logic [3:0]                   state_next;
    logic [IDX_W-1:0]             load_row_reg;
    logic [CNT_W-1:0]             load_col_reg;
    logic [IDX_W-1:0]             row_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [jls_pkg::SWEEP_W-1:0]  sweep_reg;
    logic                         zflag_reg;
    logic [jls_pkg::STATUS_W-1:0] status_reg;
    logic                         src_new_reg;
    logic                         pv_reg;
    logic [IDX_W-1:0]             pcol_reg;
    logic                         sv_reg;
    logic                         neg_reg;
    logic                         out_valid_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         fin_reg;

    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] diag_reg;
    logic signed [63:0] num_reg;
    logic [63:0]        sqo_reg;
    logic [63:0]        sqn_reg;
    logic [SQ_W-1:0]    sumo_reg;
    logic [SQ_W-1:0]    sumn_reg;
    logic [RT_W-1:0]    root_old_reg;
    logic signed [31:0] sol_reg;

    logic [CNT_W-1:0]   n_w;
    logic [IDX_W-1:0]   n_last_w;
    logic               in_acc;
    logic               out_acc;
    logic               cfg_wr;
    logic               ld_mat;
    logic               ld_rhs;
    logic               ld_old;
    logic               mac_s1;
    logic               norm_rot;
    logic               div_done;
    logic               rot_old_w;
    logic               rot_rhs_w;
    logic               shift_new_w;
    logic               copy_new_w;
    logic               converged;
    logic [15:0]        limit_eff;
    logic [ADDR_W-1:0]  raddr;
    logic [31:0]        ram_rdata;
    logic signed [31:0] a_w;
    logic signed [63:0] prod_w;
    logic signed [63:0] sqo_w;
    logic signed [63:0] sqn_w;
    logic [63:0]        num_mag;
    logic [63:0]        num_clamp;
    logic [jls_pkg::DIVD_W-1:0] dvd_w;
    logic [31:0]        dsr_w;
    logic               div_busy;
    logic [jls_pkg::DIVD_W-1:0] quo_w;
    logic signed [31:0] q_sat;
    logic               sq_start;
    logic [SQ_W-1:0]    sq_rad;
    logic               sq_busy;
    logic [RT_W-1:0]    sq_root;
    logic [RT_W-1:0]    root_diff;
    logic signed [31:0] new_tail;
    logic signed [31:0] head_w;

    logic signed [31:0]  old_q [MAX_UNKNOWNS];
    logic signed [31:0]  new_q [MAX_UNKNOWNS];
    logic signed [31:0]  rhs_q [MAX_UNKNOWNS];
    jls_pkg::cell_ctrl_t ctrl  [MAX_UNKNOWNS];

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_w = CNT_W'(1);
        end
        else if (int'(size_reg) > MAX_UNKNOWNS)
        begin
            n_w = CNT_W'(MAX_UNKNOWNS);
        end
        else
        begin
            n_w = CNT_W'(size_reg);
        end
    end

    assign n_last_w  = IDX_W'(n_w - 1'b1);
    assign limit_eff = (limit_reg == '0) ? 16'd1 : limit_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid_reg && out_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            jls_pkg::REG_SIZE:  prdata = 32'(size_reg);
            jls_pkg::REG_TOL:   prdata = 32'(tol_reg);
            jls_pkg::REG_LIMIT: prdata = 32'(limit_reg);
            default:            prdata = '0;
        endcase
    end

    assign ld_mat = in_acc && (load_col_reg < n_w);
    assign ld_rhs = in_acc && (load_col_reg == n_w);
    assign ld_old = in_acc && (load_col_reg > n_w);

    assign mac_s1   = (state_reg == S_MAC) && (cnt_reg != '0) && (cnt_reg <= n_w);
    assign norm_rot = (state_reg == S_NORM) && (cnt_reg < n_w);
    assign div_done = (state_reg == S_DIV_WAIT) && !div_busy;

    assign rot_old_w   = mac_s1 || norm_rot || ((state_reg == S_EMIT_W) && out_acc && !src_new_reg);
    assign rot_rhs_w   = state_reg == S_NUMER;
    assign shift_new_w = div_done || norm_rot || ((state_reg == S_EMIT_W) && out_acc && src_new_reg);
    assign new_tail    = (state_reg == S_DIV_WAIT) ? q_sat : new_q[0];
    assign head_w      = src_new_reg ? new_q[0] : old_q[0];

    assign root_diff = (root_old_reg > sq_root) ? root_old_reg - sq_root : sq_root - root_old_reg;
    assign converged = root_diff < RT_W'(tol_reg);
    assign copy_new_w = (state_reg == S_DECIDE) && !converged;

    for (genvar k = 0; k < MAX_UNKNOWNS; k++)
    begin : g_cell
        logic               en;
        logic               here;
        logic               wrap;
        logic signed [31:0] old_in;
        logic signed [31:0] new_in;
        logic signed [31:0] rhs_in;

        assign en     = CNT_W'(k) < n_w;
        assign here   = load_row_reg == IDX_W'(k);
        assign wrap   = n_last_w == IDX_W'(k);
        assign old_in = wrap ? old_q[0] : old_q[(k + 1) % MAX_UNKNOWNS];
        assign new_in = wrap ? new_tail : new_q[(k + 1) % MAX_UNKNOWNS];
        assign rhs_in = wrap ? rhs_q[0] : rhs_q[(k + 1) % MAX_UNKNOWNS];

        // The whole guess vector takes the new estimate, including unused cells.
        assign ctrl[k].load_old   = ld_old && here;
        assign ctrl[k].rotate_old = rot_old_w && en;
        assign ctrl[k].copy_new   = copy_new_w;
        assign ctrl[k].shift_new  = shift_new_w && en;
        assign ctrl[k].load_rhs   = ld_rhs && here;
        assign ctrl[k].rotate_rhs = rot_rhs_w && en;

        jls_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[k]),
            .load_data (value),
            .old_in    (old_in),
            .new_in    (new_in),
            .rhs_in    (rhs_in),
            .old_out   (old_q[k]),
            .new_out   (new_q[k]),
            .rhs_out   (rhs_q[k])
        );
    end

    assign raddr = (state_reg == S_CHK) ? {cnt_reg[IDX_W-1:0], cnt_reg[IDX_W-1:0]}
                                        : {row_reg, cnt_reg[IDX_W-1:0]};

    jls_ram #(
        .WIDTH (32),
        .DEPTH (2 ** ADDR_W)
    ) u_matrix (
        .clk   (clk),
        .we    (ld_mat),
        .waddr ({load_row_reg, load_col_reg[IDX_W-1:0]}),
        .wdata (value),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign a_w    = $signed(ram_rdata);
    assign prod_w = a_w * old_q[0];
    assign sqo_w  = old_q[0] * old_q[0];
    assign sqn_w  = new_q[0] * new_q[0];

    assign num_mag   = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    assign num_clamp = (num_mag > NUM_LIM) ? NUM_LIM : num_mag;
    assign dvd_w     = jls_pkg::DIVD_W'(num_clamp << FRACTION_BITS);
    assign dsr_w     = diag_reg[31] ? 32'(-diag_reg) : 32'(diag_reg);

    jls_div #(
        .DW (jls_pkg::DIVD_W),
        .VW (32)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV_GO),
        .dividend (dvd_w),
        .divisor  (dsr_w),
        .busy     (div_busy),
        .quotient (quo_w)
    );

    always_comb
    begin
        if (!neg_reg)
        begin
            q_sat = (quo_w > jls_pkg::DIVD_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff
                                                              : $signed(quo_w[31:0]);
        end
        else
        begin
            q_sat = (quo_w > jls_pkg::DIVD_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                              : -$signed(quo_w[31:0]);
        end
    end

    assign sq_start = (state_reg == S_SQO_GO) || (state_reg == S_SQN_GO);
    assign sq_rad   = (state_reg == S_SQN_GO) ? sumn_reg : sumo_reg;

    jls_sqrt #(
        .RW (SQ_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_acc && last) state_next = S_CHK;
            S_CHK:
            begin
                if (cnt_reg == n_w)
                begin
                    state_next = (zflag_reg || ram_rdata == '0) ? S_EMIT : S_MAC;
                end
            end
            S_MAC:      if (cnt_reg == n_w + 1'b1) state_next = S_NUMER;
            S_NUMER:    state_next = S_DIV_GO;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) state_next = (row_reg == n_last_w) ? S_NORM : S_MAC;
            S_NORM:     if (cnt_reg == n_w + 1'b1) state_next = S_SQO_GO;
            S_SQO_GO:   state_next = S_SQO_WAIT;
            S_SQO_WAIT: if (!sq_busy) state_next = S_SQN_GO;
            S_SQN_GO:   state_next = S_SQN_WAIT;
            S_SQN_WAIT: if (!sq_busy) state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (converged || sweep_reg >= limit_eff)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MAC;
                end
            end
            S_EMIT:     state_next = S_EMIT_W;
            S_EMIT_W:   if (out_acc) state_next = fin_reg ? S_IDLE : S_EMIT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= jls_pkg::SIZE_RST;
            tol_reg       <= jls_pkg::TOL_RST;
            limit_reg     <= jls_pkg::LIMIT_RST;
            state_reg     <= S_IDLE;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            sweep_reg     <= '0;
            zflag_reg     <= 1'b0;
            status_reg    <= jls_pkg::ST_CONVERGED;
            src_new_reg   <= 1'b0;
            pv_reg        <= 1'b0;
            pcol_reg      <= '0;
            sv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    jls_pkg::REG_SIZE:  size_reg  <= pwdata[jls_pkg::SIZE_W-1:0];
                    jls_pkg::REG_TOL:   tol_reg   <= pwdata[jls_pkg::TOL_W-1:0];
                    jls_pkg::REG_LIMIT: limit_reg <= pwdata[jls_pkg::SWEEP_W-1:0];
                    default:            ;
                endcase
            end
            if (in_acc)
            begin
                if (load_col_reg <= n_w)
                begin
                    load_col_reg <= load_col_reg + 1'b1;
                end
                else
                begin
                    load_col_reg <= '0;
                    load_row_reg <= (CNT_W'(load_row_reg) + 1'b1 >= n_w) ? '0
                                                                         : load_row_reg + 1'b1;
                end
                if (last)
                begin
                    load_row_reg <= '0;
                    load_col_reg <= '0;
                    sweep_reg    <= '0;
                    zflag_reg    <= 1'b0;
                    cnt_reg      <= '0;
                end
            end
            unique case (state_reg)
                S_CHK:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != '0 && ram_rdata == '0)
                    begin
                        zflag_reg <= 1'b1;
                    end
                    if (cnt_reg == n_w)
                    begin
                        cnt_reg     <= '0;
                        row_reg     <= '0;
                        pv_reg      <= 1'b0;
                        idx_reg     <= '0;
                        status_reg  <= jls_pkg::ST_ZERO_DIAG;
                        src_new_reg <= 1'b0;
                    end
                end
                S_MAC:
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    pv_reg   <= mac_s1;
                    pcol_reg <= IDX_W'(cnt_reg - 1'b1);
                    if (state_next != S_MAC)
                    begin
                        cnt_reg <= '0;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        row_reg <= row_reg + 1'b1;
                        pv_reg  <= 1'b0;
                        cnt_reg <= '0;
                        sv_reg  <= 1'b0;
                        if (row_reg == n_last_w)
                        begin
                            row_reg   <= '0;
                            sweep_reg <= sweep_reg + 1'b1;
                        end
                    end
                end
                S_NORM:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sv_reg  <= norm_rot;
                end
                S_DECIDE:
                begin
                    cnt_reg     <= '0;
                    row_reg     <= '0;
                    pv_reg      <= 1'b0;
                    idx_reg     <= '0;
                    src_new_reg <= 1'b1;
                    status_reg  <= converged ? jls_pkg::ST_CONVERGED : jls_pkg::ST_LIMIT;
                end
                S_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    fin_reg       <= idx_reg == n_last_w;
                end
                S_EMIT_W:
                begin
                    if (out_acc)
                    begin
                        out_valid_reg <= 1'b0;
                        idx_reg       <= idx_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHK || state_reg == S_DIV_WAIT || state_reg == S_DECIDE)
        begin
            acc_reg  <= '0;
            sumo_reg <= '0;
            sumn_reg <= '0;
        end
        if (mac_s1)
        begin
            prod_reg <= prod_w;
            if (IDX_W'(cnt_reg - 1'b1) == row_reg)
            begin
                diag_reg <= a_w;
            end
        end
        if (state_reg == S_MAC && pv_reg && pcol_reg != row_reg)
        begin
            acc_reg <= acc_reg + (prod_reg >>> FRACTION_BITS);
        end
        if (state_reg == S_NUMER)
        begin
            num_reg <= 64'(rhs_q[0]) - acc_reg;
            neg_reg <= 1'b0;
        end
        if (state_reg == S_DIV_GO)
        begin
            neg_reg <= num_reg[63] ^ diag_reg[31];
        end
        if (norm_rot)
        begin
            sqo_reg <= 64'(sqo_w);
            sqn_reg <= 64'(sqn_w);
        end
        if (state_reg == S_NORM && sv_reg)
        begin
            sumo_reg <= sumo_reg + SQ_W'(sqo_reg);
            sumn_reg <= sumn_reg + SQ_W'(sqn_reg);
        end
        if (state_reg == S_SQO_WAIT && !sq_busy)
        begin
            root_old_reg <= sq_root;
        end
        if (state_reg == S_EMIT)
        begin
            sol_reg <= head_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign index     = idx_reg;
    assign solution  = sol_reg;
    assign sweeps    = sweep_reg;
    assign status    = status_reg;
    assign final_res = fin_reg;

endmodule

[sv/jls_checker.sv]
// Port-level checks of the Jacobi linear solver and their binding.
module jls_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [31:0]           solution,
    input logic [jls_pkg::SWEEP_W-1:0]  sweeps,
    input logic [jls_pkg::STATUS_W-1:0] status,
    input logic                         final_res
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(solution))
        else $error("result changed while stalled");

    // No input is taken while results are being delivered.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // The block is ready for a new system right after the final result.
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && final_res |=> !out_valid && in_ready)
        else $error("not idle after the final result");

    // A zero diagonal means no sweep was run.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == jls_pkg::ST_ZERO_DIAG |-> sweeps == '0)
        else $error("sweeps reported with a zero diagonal");

endmodule

bind jacobi_linear_solver jls_checker u_jls_checker (.*);

[tb/sv/jls_solution_checker.sv]
// Checker for the Jacobi solver: observes transfers, predicts solutions and compares them.
module jls_solution_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jls_pkg::PADDR_W-1:0]   paddr,
    input  logic [jls_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [31:0]            value,
    input  logic                          last,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [3:0]                    index,
    input  logic signed [31:0]            solution,
    input  logic [jls_pkg::SWEEP_W-1:0]   sweeps,
    input  logic [jls_pkg::STATUS_W-1:0]  status,
    input  logic                          final_res,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX = 16;
    localparam int FB   = 24;

    typedef struct packed {
        logic [3:0]                   idx;
        logic signed [31:0]           sol;
        logic [jls_pkg::SWEEP_W-1:0]  swp;
        logic [jls_pkg::STATUS_W-1:0] st;
        logic                         fin;
    } solution_rec_t;

    typedef logic signed [31:0] vec_t [NMAX];

    logic [jls_pkg::SIZE_W-1:0]   size_reg;
    logic [jls_pkg::TOL_W-1:0]    tol_reg;
    logic [jls_pkg::SWEEP_W-1:0]  limit_reg;
    logic signed [31:0]  coef [NMAX*NMAX];
    vec_t                rhs;
    vec_t                x_prev;
    vec_t                x_next;
    int                  load_row;
    int                  load_col;
    solution_rec_t       solution_q [$];

    function automatic int active_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > NMAX)
            return NMAX;
        return int'(size_reg);
    endfunction

    function automatic logic [79:0] vec_norm(input vec_t v, input int n);
        logic [79:0] acc;
        logic [79:0] c;
        logic [79:0] r;
        longint      s;
        acc = '0;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            s = longint'(v[i]);
            if (s < 0)
                s = -s;
            acc += 80'(s) * 80'(s);
        end
        for (int b = 35; b >= 0; b--)
        begin
            c = r | (80'd1 << b);
            if (c * c <= acc)
                r = c;
        end
        return r;
    endfunction

    task automatic jacobi_sweep(input int n);
        longint lim;
        longint sum;
        longint num;
        longint q;
        longint p;
        lim = longint'(1) << (62 - FB);
        for (int i = 0; i < n; i++)
        begin
            sum = 0;
            for (int j = 0; j < n; j++)
            begin
                if (j != i)
                begin
                    p = longint'(coef[i*NMAX+j]) * longint'(x_prev[j]);
                    sum += p >>> FB;
                end
            end
            num = longint'(rhs[i]) - sum;
            if (num > lim)
                num = lim;
            if (num < -lim)
                num = -lim;
            q = (num * (longint'(1) << FB)) / longint'(coef[i*NMAX+i]);
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
            x_next[i] = 32'(q);
        end
    endtask

    task automatic solve_and_queue();
        int                           n;
        int                           cap;
        int                           count;
        logic                         zero_diag;
        logic [jls_pkg::STATUS_W-1:0] st;
        logic [79:0]                  na;
        logic [79:0]                  nb;
        logic [79:0]                  diff;
        vec_t                         x_out;
        solution_rec_t                rec;
        n = active_size();
        cap = (limit_reg == 0) ? 1 : int'(limit_reg);
        count = 0;
        zero_diag = 1'b0;
        st = jls_pkg::ST_CONVERGED;
        for (int i = 0; i < n; i++)
            if (coef[i*NMAX+i] == 0)
                zero_diag = 1'b1;
        if (zero_diag)
        begin
            st = jls_pkg::ST_ZERO_DIAG;
            x_out = x_prev;
        end
        else
        begin
            forever
            begin
                jacobi_sweep(n);
                count++;
                na = vec_norm(x_prev, n);
                nb = vec_norm(x_next, n);
                diff = (na > nb) ? na - nb : nb - na;
                if (diff < 80'(tol_reg))
                begin
                    st = jls_pkg::ST_CONVERGED;
                    break;
                end
                x_prev = x_next;
                if (count >= cap)
                begin
                    st = jls_pkg::ST_LIMIT;
                    break;
                end
            end
            x_out = x_next;
        end
        for (int i = 0; i < n; i++)
        begin
            rec.idx = 4'(i);
            rec.sol = x_out[i];
            rec.swp = jls_pkg::SWEEP_W'(count);
            rec.st  = st;
            rec.fin = (i == n - 1);
            solution_q.push_back(rec);
        end
    endtask

    task automatic load_value(input logic signed [31:0] v, input logic is_last);
        int n;
        int row;
        n = active_size();
        row = load_row % NMAX;
        if (load_col < n)
        begin
            coef[row*NMAX+load_col] = v;
            load_col++;
        end
        else if (load_col == n)
        begin
            rhs[row] = v;
            load_col++;
        end
        else
        begin
            x_prev[row] = v;
            load_col = 0;
            load_row = (row + 1 >= n) ? 0 : row + 1;
        end
        if (is_last)
        begin
            load_row = 0;
            load_col = 0;
            solve_and_queue();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        solution_rec_t exp_rec;
        if (!rst_n)
        begin
            size_reg  = jls_pkg::SIZE_RST;
            tol_reg   = jls_pkg::TOL_RST;
            limit_reg = jls_pkg::LIMIT_RST;
            load_row  = 0;
            load_col  = 0;
            solution_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    jls_pkg::REG_SIZE:  size_reg  = pwdata[jls_pkg::SIZE_W-1:0];
                    jls_pkg::REG_TOL:   tol_reg   = pwdata[jls_pkg::TOL_W-1:0];
                    jls_pkg::REG_LIMIT: limit_reg = pwdata[jls_pkg::SWEEP_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (solution_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected transfer idx=%0d sol=%h swp=%0d st=%0d fin=%0d",
                             $realtime, index, solution, sweeps, status, final_res);
                end
                else
                begin
                    exp_rec = solution_q.pop_front();
                    if (exp_rec.idx !== index || exp_rec.sol !== solution ||
                        exp_rec.swp !== sweeps || exp_rec.st !== status ||
                        exp_rec.fin !== final_res)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected idx=%0d sol=%h swp=%0d st=%0d fin=%0d",
                                 $realtime, exp_rec.idx, exp_rec.sol, exp_rec.swp, exp_rec.st,
                                 exp_rec.fin);
                        $display("%0t:          actual   idx=%0d sol=%h swp=%0d st=%0d fin=%0d",
                                 $realtime, index, solution, sweeps, status, final_res);
                    end
                end
            end
            if (in_valid && in_ready)
                load_value(value, last);
            pending = solution_q.size();
        end
    end

endmodule

[tb/sv/tb_jacobi_linear_solver.sv]
// Testbench top for the Jacobi solver: clock, reset, stimulus and verdict.
module tb_jacobi_linear_solver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_ITEMS = 460;
    localparam int IDLE_LIMIT   = 200000;
    localparam logic signed [31:0] ONE = 32'sh0100_0000;

    typedef enum int {SYS_WILD, SYS_DOMINANT, SYS_EXACT} sys_kind_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [jls_pkg::PADDR_W-1:0]   paddr;
    logic [jls_pkg::PDATA_W-1:0]   pwdata;
    logic [jls_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [31:0]            value;
    logic                          last;
    logic                          out_valid;
    logic                          out_ready;
    logic [3:0]                    index;
    logic signed [31:0]            solution;
    logic [jls_pkg::SWEEP_W-1:0]   sweeps;
    logic [jls_pkg::STATUS_W-1:0]  status;
    logic                          final_res;
    int                            fail_count;
    int                            pending;
    logic                          in_taken;
    int                            idle_cycles;
    int                            items;
    int                            stall_left;

    jacobi_linear_solver dut (.*);

    jls_solution_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    out_ready = 1'b0;
                    stall_left = $urandom_range(5, 40);
                end
                3, 4, 5, 6, 7, 8:
                begin
                    out_ready = 1'b0;
                    stall_left = $urandom_range(0, 2);
                end
                default:
                begin
                    out_ready = 1'b1;
                    stall_left = $urandom_range(0, 40);
                end
            endcase
        end
    end

    function automatic int pick_gap(input logic burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_value(input logic signed [31:0] v, input logic is_last, input int gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        value    = v;
        last     = is_last;
        items++;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    task automatic drain_and_settle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_settings(input int sz, input int tol, input int lim);
        drain_and_settle();
        reg_write(jls_pkg::REG_SIZE, 32'(sz));
        reg_write(jls_pkg::REG_TOL, 32'(tol));
        reg_write(jls_pkg::REG_LIMIT, 32'(lim));
    endtask

    // Streams one system in load order; count cuts it short, with_last marks the final value.
    task automatic send_system(input int n, input sys_kind_t kind, input int count,
                               input logic with_last);
        logic signed [31:0] diag [16];
        logic signed [31:0] rhs_v [16];
        logic signed [31:0] v;
        logic               burst;
        int                 pos;
        int                 col;
        int                 row;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            rhs_v[i] = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            diag[i] = 32'(n) * ONE + $signed($urandom_range(0, ONE));
            if ($urandom_range(0, 1))
                diag[i] = -diag[i];
        end
        if (kind == SYS_DOMINANT && $urandom_range(0, 7) == 0)
            diag[$urandom_range(0, n - 1)] = 0;
        pos = 0;
        for (row = 0; row < n && pos < count; row++)
        begin
            for (col = 0; col < n + 2 && pos < count; col++)
            begin
                if (kind == SYS_WILD)
                    v = $signed($urandom());
                else if (col == row)
                    v = (kind == SYS_EXACT) ? ONE : diag[row];
                else if (col < n)
                    v = (kind == SYS_EXACT) ? 32'sd0
                        : $signed($urandom_range(0, ONE)) - (ONE >>> 1);
                else if (col == n || kind == SYS_EXACT)
                    v = rhs_v[row];
                else
                    v = $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
                pos++;
                send_value(v, with_last && pos == count, pick_gap(burst));
            end
        end
    endtask

    function automatic int eff_size(input int sz);
        if (sz == 0)
            return 1;
        return (sz > 16) ? 16 : sz;
    endfunction

    initial
    begin
        int        sz;
        int        n;
        int        tol;
        int        lim;
        int        full;
        int        systems;
        int        room;
        logic      partial;
        logic      big;
        logic      cut;
        sys_kind_t kind;

        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        value    = '0;
        last     = 1'b0;
        out_ready  = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        items    = 0;
        partial  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_settings(1, 168, 4);
        send_value(32'sd1, 1'b0, 0);
        send_value(32'sh7FFF_FFFF, 1'b0, 0);
        send_value(32'sd0, 1'b1, 0);
        send_value(32'sd1, 1'b0, 0);
        send_value(32'sh8000_0000, 1'b0, 0);
        send_value(32'sd0, 1'b1, 0);
        send_value(32'sd0, 1'b0, 0);
        send_value(32'sh1234_5678, 1'b0, 0);
        send_value(32'sh8000_0000, 1'b1, 0);
        write_settings(2, 168, 4);
        send_value(32'sh7FFF_FFFF, 1'b0, 0);
        send_value(32'sh8000_0000, 1'b0, 1);
        send_value(32'sh7FFF_FFFF, 1'b0, 0);
        send_value(32'sh8000_0000, 1'b0, 2);
        send_value(32'sh8000_0000, 1'b0, 0);
        send_value(32'sh7FFF_FFFF, 1'b0, 0);
        send_value(32'sh7FFF_FFFF, 1'b0, 0);
        send_value(32'sh8000_0000, 1'b1, 0);
        send_value(ONE, 1'b0, 0);
        send_value(-ONE, 1'b0, 3);
        send_value(ONE, 1'b1, 0);

        // Full-size load before the random systems, so every store entry is written before any of their early lasts.
        write_settings(16, 168, 3);
        send_system(16, SYS_DOMINANT, 16 * 18, 1'b1);

        while (items < TARGET_ITEMS)
        begin
            room = TARGET_ITEMS - items;
            case ($urandom_range(0, 11))
                0:       sz = 0;
                1:       sz = $urandom_range(17, 31);
                2:       sz = 16;
                default: sz = $urandom_range(1, 5);
            endcase
            n = eff_size(sz);
            full = n * (n + 2);
            cut = (full > room + 40);
            case ($urandom_range(0, 7))
                0:       tol = 0;
                1:       tol = 32'h7FFF_FFFF;
                default: tol = $urandom_range(0, 1 << 20);
            endcase
            case ($urandom_range(0, 7))
                0:       lim = 0;
                1:       lim = 1;
                2:       lim = 65535;
                default: lim = $urandom_range(2, 10);
            endcase
            if (lim == 65535 && (partial || cut))
                lim = 10;
            big = (lim == 65535);
            if (big && tol == 0)
                tol = 1;
            write_settings(sz, tol, lim);
            if (partial)
            begin
                send_system(n, SYS_WILD, $urandom_range(1, n + 3), 1'b1);
                partial = 1'b0;
            end
            systems = (n == 16 || cut) ? 1 : $urandom_range(2, 5);
            while (systems > 1 && systems * full > room + 40)
                systems--;
            for (int s = 0; s < systems; s++)
            begin
                if (big)
                    send_system(n, SYS_EXACT, full, 1'b1);
                else
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2:    kind = SYS_WILD;
                        3, 4:       kind = SYS_EXACT;
                        default:    kind = SYS_DOMINANT;
                    endcase
                    if (cut)
                        send_system(n, kind, $urandom_range(1, room + 1), 1'b1);
                    else if ($urandom_range(0, 5) == 0)
                        send_system(n, kind, $urandom_range(1, full), 1'b1);
                    else
                        send_system(n, kind, full, 1'b1);
                end
            end
            if (!big && !cut && items < TARGET_ITEMS && $urandom_range(0, 3) == 0)
            begin
                send_system(n, SYS_DOMINANT, $urandom_range(1, full), 1'b0);
                partial = 1'b1;
            end
        end
        if (partial)
            send_system(1, SYS_WILD, 3, 1'b1);

        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
sv/jls_pkg.sv
sv/jls_ram.sv
sv/jls_cell.sv
sv/jls_div.sv
sv/jls_sqrt.sv
sv/jacobi_linear_solver.sv
sv/jls_checker.sv
tb/sv/jls_solution_checker.sv
tb/sv/tb_jacobi_linear_solver.sv
